// ----- hw/rtl/kfct_pkg.sv -----
// shared types and codes for the keyed fault counter table
package kfct_pkg;

  // operation codes
  localparam logic [1:0] OP_SET_THR = 2'd0;
  localparam logic [1:0] OP_RECORD  = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // field widths
  localparam int KEY_W = 64;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one counter record
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] thr;
  } rec_t;

  // key scan status towards the controller
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

// ----- hw/rtl/kfct_if.sv -----
// request and result channel interfaces

interface kfct_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [kfct_pkg::KEY_W-1:0]     fault_key;
  logic [kfct_pkg::CNT_W-1:0]     threshold_value;

  modport source (output valid, output operation, output fault_key,
                  output threshold_value, input ready);
  modport sink   (input valid, input operation, input fault_key,
                  input threshold_value, output ready);
endinterface

interface kfct_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [kfct_pkg::CNT_W-1:0]     occurrence_count;
  logic                           fault_alarm;

  modport source (output valid, output status, output occurrence_count,
                  output fault_alarm, input ready);
  modport sink   (input valid, input status, input occurrence_count,
                  input fault_alarm, output ready);
endinterface

// ----- hw/rtl/kfct_key_scan.sv -----
// key memory with a pipelined sequential lookup and an allocation write port
module kfct_key_scan #(
  parameter int ENTRIES   = 16,
  parameter int KEY_CHARS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [8*KEY_CHARS-1:0]              start_key,
  input  logic [$clog2(ENTRIES+1)-1:0]        used,
  input  logic                                wr_en,
  input  logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
  output kfct_pkg::scan_res_t                 res,
  output logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] hit_idx
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W = $clog2(ENTRIES + 1);
  localparam int SKEY_W = 8 * KEY_CHARS;

  logic [SKEY_W-1:0] mem [ENTRIES];
  logic [SKEY_W-1:0] rd_data_r;
  logic [SKEY_W-1:0] key_r;
  logic              busy_r, busy_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [USED_W-1:0] issue_r, issue_nxt;
  logic              rd_en;
  logic              hit;
  logic              done;

  // compare the entry read in the previous cycle
  assign hit  = busy_r && cmp_v_r && (rd_data_r == key_r);
  assign done = busy_r && (hit || (!cmp_v_r && (issue_r >= used)));
  assign rd_en = busy_r && !hit && (issue_r < used);

  assign res.done = done;
  assign res.hit  = hit;
  assign hit_idx  = cmp_idx_r;

  // scan sequencing
  always_comb begin
    busy_nxt    = busy_r;
    cmp_v_nxt   = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    issue_nxt   = issue_r;
    if (start) begin
      busy_nxt  = 1'b1;
      issue_nxt = '0;
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end else if (rd_en) begin
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = issue_r[IDX_W-1:0];
        issue_nxt   = issue_r + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    issue_r   <= issue_nxt;
    if (start) begin
      key_r <= start_key;
    end
  end

  // key memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

endmodule

// ----- hw/rtl/kfct_rec_mem.sv -----
// count and threshold memory with registered read
module kfct_rec_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx,
  output kfct_pkg::rec_t                      rd_rec,
  input  logic                                wr_en,
  input  logic [(ENTRIES>1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
  input  kfct_pkg::rec_t                      wr_rec
);

  kfct_pkg::rec_t mem [ENTRIES];
  kfct_pkg::rec_t rd_rec_r;

  assign rd_rec = rd_rec_r;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec_r <= mem[rd_idx];
    end
  end

endmodule

// ----- hw/rtl/keyed_fault_counter_table.sv -----
// top level: keyed fault counter table with sequential key scan
// a request passes through the key scan, the record update for a found or new entry, and the
// result load; the result load waits while the result slot is full
// a new request is taken only in idle, after the result of the last one has been loaded
// reset: synchronous active low; clears the entry count, controller state and result valid
// the key and record memories are not cleared; only entries below the count are read
module keyed_fault_counter_table #(
  parameter int ENTRIES   = 16,
  parameter int KEY_CHARS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  kfct_in_if.sink          in_if,
  kfct_out_if.source       out_if
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W = $clog2(ENTRIES + 1);
  localparam int SKEY_W = 8 * KEY_CHARS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [USED_W-1:0]          used_r, used_nxt;
  logic [1:0]                 op_r;
  logic [kfct_pkg::CNT_W-1:0] thr_r;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       new_r, new_nxt;
  logic [1:0]                 res_status_r, res_status_nxt;
  logic [kfct_pkg::CNT_W-1:0] res_count_r, res_count_nxt;
  logic                       res_alarm_r, res_alarm_nxt;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [kfct_pkg::CNT_W-1:0] out_count_r;
  logic                       out_alarm_r;

  logic                       accept;
  logic                       out_load;
  logic [SKEY_W-1:0]          canon_key;
  logic                       alive;
  kfct_pkg::scan_res_t        scan_res;
  logic [IDX_W-1:0]           scan_idx;
  logic                       key_wr;
  logic                       rec_rd;
  logic                       rec_wr;
  kfct_pkg::rec_t             rec_cur;
  kfct_pkg::rec_t             rec_rd_data;
  kfct_pkg::rec_t             rec_new;

  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_if.ready);

  // cut the key at the first zero character
  always_comb begin
    alive     = 1'b1;
    canon_key = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (in_if.fault_key[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        canon_key[8*i +: 8] = in_if.fault_key[8*i +: 8];
      end
    end
  end

  kfct_key_scan #(
    .ENTRIES   (ENTRIES),
    .KEY_CHARS (KEY_CHARS)
  ) u_key_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .start_key (canon_key),
    .used      (used_r),
    .wr_en     (key_wr),
    .wr_idx    (idx_nxt),
    .res       (scan_res),
    .hit_idx   (scan_idx)
  );

  kfct_rec_mem #(
    .ENTRIES (ENTRIES)
  ) u_rec_mem (
    .clk    (clk),
    .rd_en  (rec_rd),
    .rd_idx (scan_idx),
    .rd_rec (rec_rd_data),
    .wr_en  (rec_wr),
    .wr_idx (idx_r),
    .wr_rec (rec_new)
  );

  // record update for a found or new entry
  always_comb begin
    rec_cur = new_r ? '0 : rec_rd_data;
    rec_new = rec_cur;
    res_alarm_nxt = 1'b0;
    case (op_r)
      kfct_pkg::OP_SET_THR: rec_new.thr = thr_r;
      kfct_pkg::OP_RECORD: begin
        if (rec_cur.count != kfct_pkg::CNT_MAX) begin
          rec_new.count = rec_cur.count + kfct_pkg::CNT_W'(1);
        end
        res_alarm_nxt = (rec_cur.thr != '0) && (rec_new.count >= rec_cur.thr);
      end
      kfct_pkg::OP_RESET: rec_new.count = '0;
      default: rec_new = rec_cur;
    endcase
  end

  assign rec_wr = (state_r == S_UPD) && (op_r != kfct_pkg::OP_QUERY);

  // controller
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    key_wr         = 1'b0;
    rec_rd         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            rec_rd         = 1'b1;
            idx_nxt        = scan_idx;
            new_nxt        = 1'b0;
            res_status_nxt = kfct_pkg::ST_FOUND;
            state_nxt      = S_UPD;
          end else if (op_r == kfct_pkg::OP_RESET || op_r == kfct_pkg::OP_QUERY) begin
            res_status_nxt = kfct_pkg::ST_ABSENT;
            res_count_nxt  = '0;
            state_nxt      = S_RESP;
          end else if (used_r < USED_W'(ENTRIES)) begin
            key_wr         = 1'b1;
            idx_nxt        = used_r[IDX_W-1:0];
            used_nxt       = used_r + USED_W'(1);
            new_nxt        = 1'b1;
            res_status_nxt = kfct_pkg::ST_CREATED;
            state_nxt      = S_UPD;
          end else begin
            res_status_nxt = kfct_pkg::ST_FULL;
            res_count_nxt  = '0;
            state_nxt      = S_RESP;
          end
        end
      end
      S_UPD: begin
        res_count_nxt = rec_new.count;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_if.operation;
      thr_r <= in_if.threshold_value;
    end
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    if (state_r == S_UPD) begin
      res_alarm_r <= res_alarm_nxt;
    end else if (state_r == S_SCAN) begin
      res_alarm_r <= 1'b0;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= res_count_r;
      out_alarm_r  <= res_alarm_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_status_r;
  assign out_if.occurrence_count = out_count_r;
  assign out_if.fault_alarm      = out_alarm_r;

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the keyed fault counter table with a scoreboard and random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;
  localparam int KEY_CHARS = 8;
  localparam int POOL_SIZE = 20;
  localparam int PHASE_ITEMS = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]                 status;
    logic [kfct_pkg::CNT_W-1:0] count;
    logic                       alarm;
  } fault_result_t;

  // mirror of the counter table and the queue of results it predicts
  class fault_table_scoreboard;
    logic [kfct_pkg::KEY_W-1:0] entry_key [ENTRIES];
    logic [kfct_pkg::CNT_W-1:0] entry_count [ENTRIES];
    logic [kfct_pkg::CNT_W-1:0] entry_thr [ENTRIES];
    int                         entries_used;
    fault_result_t              pending_results [$];
    int                         errors;
    int                         results_seen;

    function new();
      entries_used = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // key up to the first zero character
    function logic [kfct_pkg::KEY_W-1:0] canonical_key(logic [kfct_pkg::KEY_W-1:0] raw);
      logic [kfct_pkg::KEY_W-1:0] k;
      bit                         ended;
      k = '0;
      ended = 0;
      for (int i = 0; i < KEY_CHARS; i++) begin
        if (raw[8*i +: 8] == 8'd0) ended = 1;
        if (!ended) k[8*i +: 8] = raw[8*i +: 8];
      end
      return k;
    endfunction

    // accepted request: update the table copy and queue the result it gives
    function void note_request(logic [1:0] op, logic [kfct_pkg::KEY_W-1:0] raw_key,
                               logic [kfct_pkg::CNT_W-1:0] thr);
      logic [kfct_pkg::KEY_W-1:0] key;
      fault_result_t              res;
      int                         idx;
      key = canonical_key(raw_key);
      res = '0;
      idx = -1;
      for (int i = 0; i < entries_used; i++) begin
        if (idx < 0 && entry_key[i] == key) idx = i;
      end

      if (op == kfct_pkg::OP_SET_THR || op == kfct_pkg::OP_RECORD) begin
        if (idx >= 0) begin
          res.status = kfct_pkg::ST_FOUND;
        end else if (entries_used < ENTRIES) begin
          idx = entries_used;
          entries_used++;
          entry_key[idx] = key;
          entry_count[idx] = '0;
          entry_thr[idx] = '0;
          res.status = kfct_pkg::ST_CREATED;
        end else begin
          res.status = kfct_pkg::ST_FULL;
        end
        if (idx >= 0) begin
          if (op == kfct_pkg::OP_SET_THR) begin
            entry_thr[idx] = thr;
          end else begin
            if (entry_count[idx] != kfct_pkg::CNT_MAX)
              entry_count[idx] = entry_count[idx] + 16'd1;
            res.alarm = (entry_thr[idx] != '0) && (entry_count[idx] >= entry_thr[idx]);
          end
          res.count = entry_count[idx];
        end
      end else if (idx >= 0) begin
        res.status = kfct_pkg::ST_FOUND;
        if (op == kfct_pkg::OP_RESET) entry_count[idx] = '0;
        res.count = entry_count[idx];
      end else begin
        res.status = kfct_pkg::ST_ABSENT;
      end
      pending_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [1:0] status, logic [kfct_pkg::CNT_W-1:0] count,
                               logic alarm);
      fault_result_t exp_res;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with nothing outstanding: status %0d count %0d alarm %0d",
                   results_seen, status, count, alarm);
        return;
      end
      exp_res = pending_results.pop_front();
      if (status !== exp_res.status || count !== exp_res.count || alarm !== exp_res.alarm) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d mismatch: expected status %0d count %0d alarm %0d, ",
                    "got status %0d count %0d alarm %0d"},
                   results_seen, exp_res.status, exp_res.count, exp_res.alarm,
                   status, count, alarm);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_off;
  int   sender_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  logic [kfct_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  fault_table_scoreboard sb = new();

  kfct_in_if  in_ch ();
  kfct_out_if out_ch ();

  keyed_fault_counter_table #(
    .ENTRIES  (ENTRIES),
    .KEY_CHARS(KEY_CHARS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = kfct_pkg::OP_QUERY;
    in_ch.fault_key = '0;
    in_ch.threshold_value = '0;
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  end

  // overall cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
  initial cycle_count = 0;

  // result side: check accepted results, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.occurrence_count, out_ch.fault_alarm);
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one request, idling first at random, and wait for it to be taken
  task automatic send_request(logic [1:0] op, logic [kfct_pkg::KEY_W-1:0] key,
                              logic [kfct_pkg::CNT_W-1:0] thr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.fault_key <= key;
    in_ch.threshold_value <= thr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, key, thr);
  endtask

  // same name with junk after the terminating zero character
  function automatic logic [kfct_pkg::KEY_W-1:0] garble_tail(logic [kfct_pkg::KEY_W-1:0] k);
    logic [kfct_pkg::KEY_W-1:0] g;
    bit                         ended;
    g = k;
    ended = 0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (ended) g[8*i +: 8] = 8'($urandom_range(255));
      if (k[8*i +: 8] == 8'd0) ended = 1;
    end
    return g;
  endfunction

  // nonzero name of one to eight characters
  function automatic logic [kfct_pkg::KEY_W-1:0] make_name();
    logic [kfct_pkg::KEY_W-1:0] k;
    int                         len;
    k = '0;
    len = int'($urandom_range(1, KEY_CHARS));
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // one random request, mostly on a small set of names so entries get hit again
  task automatic send_random_event();
    logic [1:0]                 op;
    logic [kfct_pkg::KEY_W-1:0] key;
    logic [kfct_pkg::CNT_W-1:0] thr;
    int                         r;
    r = $urandom_range(99);
    if (r < 15) op = kfct_pkg::OP_SET_THR;
    else if (r < 60) op = kfct_pkg::OP_RECORD;
    else if (r < 70) op = kfct_pkg::OP_RESET;
    else op = kfct_pkg::OP_QUERY;
    r = $urandom_range(99);
    if (r < 75) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (r < 90) key = garble_tail(key_pool[$urandom_range(POOL_SIZE - 1)]);
    else key = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 15) thr = '0;
    else if (r < 85) thr = 16'($urandom_range(1, 6));
    else thr = 16'($urandom);
    send_request(op, key, thr);
  endtask

  localparam logic [kfct_pkg::KEY_W-1:0] KEY_A       = 64'h0000_0041_5F54_4C46;
  localparam logic [kfct_pkg::KEY_W-1:0] KEY_A_ALIAS = 64'hA5C3_0041_5F54_4C46;
  localparam logic [kfct_pkg::KEY_W-1:0] KEY_EMPTY_ALIAS = 64'h1234_5678_9ABC_DE00;
  localparam logic [kfct_pkg::KEY_W-1:0] KEY_FULL    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [kfct_pkg::KEY_W-1:0] KEY_B       = 64'h0000_0000_0042_4C46;
  localparam logic [kfct_pkg::KEY_W-1:0] KEY_LATE    = 64'h0000_0000_0000_7A7A;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: absent key, then count one key up against the largest threshold
    send_request(kfct_pkg::OP_QUERY, KEY_A, 16'hFFFF);
    send_request(kfct_pkg::OP_RESET, KEY_A, 16'h0000);
    send_request(kfct_pkg::OP_SET_THR, KEY_A, kfct_pkg::CNT_MAX);
    for (int i = 0; i < 5; i++) send_request(kfct_pkg::OP_RECORD, KEY_A, 16'h0000);
    send_request(kfct_pkg::OP_RECORD, KEY_A, 16'h1234);
    send_request(kfct_pkg::OP_QUERY, KEY_A, 16'h0000);
    send_request(kfct_pkg::OP_RESET, KEY_A, 16'h0000);
    // directed: aliased names, empty name, full-length name, alarm threshold
    send_request(kfct_pkg::OP_RECORD, KEY_A_ALIAS, 16'h0000);
    send_request(kfct_pkg::OP_SET_THR, KEY_A_ALIAS, 16'h0000);
    send_request(kfct_pkg::OP_RECORD, '0, 16'h0000);
    send_request(kfct_pkg::OP_RECORD, KEY_EMPTY_ALIAS, 16'hFFFF);
    send_request(kfct_pkg::OP_SET_THR, KEY_FULL, 16'h0001);
    send_request(kfct_pkg::OP_RECORD, KEY_FULL, 16'h0000);
    send_request(kfct_pkg::OP_RECORD, KEY_FULL, 16'h0000);
    send_request(kfct_pkg::OP_SET_THR, KEY_B, 16'h0003);
    for (int i = 0; i < 3; i++) send_request(kfct_pkg::OP_RECORD, KEY_B, 16'h0000);
    send_request(kfct_pkg::OP_QUERY, KEY_B, 16'hFFFF);
    send_request(kfct_pkg::OP_RESET, KEY_B, 16'hA5A5);

    // random traffic in four idling phases
    foreach (key_pool[i]) key_pool[i] = make_name();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct = 85; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct <= 85; end
        default: begin sender_idle_pct = 19; recv_stall_pct <= 19; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming, so the input stalls
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
          for (int i = 0; i < 12; i++) send_random_event();
        join
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_event();
    end

    // table full: fill any free entries, then try a new name
    sender_idle_pct = 0;
    recv_stall_pct <= 0;
    while (sb.entries_used < ENTRIES)
      send_request(kfct_pkg::OP_SET_THR,
                   {8'($urandom_range(1, 255)), 32'($urandom), 24'h5A5A5A},
                   16'($urandom));
    send_request(kfct_pkg::OP_SET_THR, KEY_LATE, 16'h0002);
    send_request(kfct_pkg::OP_RECORD, KEY_LATE, 16'h0000);
    send_request(kfct_pkg::OP_QUERY, KEY_LATE, 16'h0000);
    send_request(kfct_pkg::OP_RESET, KEY_LATE, 16'h0000);

    // drain
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
